// File: design/delta_list_timer_manager_macros.svh
// Assertion helpers for the delta list timer manager.
`ifndef DELTA_LIST_TIMER_MANAGER_MACROS_SVH
`define DELTA_LIST_TIMER_MANAGER_MACROS_SVH

// Same-cycle implication, gated by reset.
`define DLTM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dltm assertion failed");

// Next-cycle implication, gated by reset.
`define DLTM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dltm assertion failed");

`endif

// File: design/dltm_pkg.sv
package dltm_pkg;

   localparam int unsigned MAX_TIMERS_DEF = 16;
   localparam int unsigned TIME_BITS_DEF  = 24;

   localparam int unsigned KIND_W  = 2;
   localparam int unsigned DUR_W   = 24;
   localparam int unsigned ID_W    = 4;
   localparam int unsigned RKIND_W = 3;
   localparam int unsigned TICK_W  = 16;

   localparam logic [TICK_W-1:0] TICK_RESET = 16'd1000;

   localparam logic [KIND_W-1:0] OP_START = 2'd0;
   localparam logic [KIND_W-1:0] OP_STOP  = 2'd1;
   localparam logic [KIND_W-1:0] OP_QUERY = 2'd2;
   localparam logic [KIND_W-1:0] OP_TICK  = 2'd3;

   localparam logic [RKIND_W-1:0] RES_STARTED  = 3'd0;
   localparam logic [RKIND_W-1:0] RES_FULL     = 3'd1;
   localparam logic [RKIND_W-1:0] RES_STOP_ACK = 3'd2;
   localparam logic [RKIND_W-1:0] RES_QUERY    = 3'd3;
   localparam logic [RKIND_W-1:0] RES_FIRED    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_INSERT,
      ST_STOP_WALK,
      ST_FOLD,
      ST_TICK,
      ST_FIRE
   } state_type;

endpackage

// File: design/delta_list_timer_manager.sv
// Delta list timer manager: one request at a time, busy while it is worked on.
// A query, a refused start and a stop of an idle id are answered from dispatch;
// a start walks one group per cycle through the shared add/sub unit and may insert;
// a stop walks the list and may fold a dropped group; a tick with nothing fired gives no result, else one per fired id.
// Throughput: next request taken at the edge that takes the last result; no stall.
// Synchronous active-high reset empties the list, stops all timers, tick_ms = 1000.
`include "delta_list_timer_manager_macros.svh"

module delta_list_timer_manager #(
   parameter int unsigned MAX_TIMERS = dltm_pkg::MAX_TIMERS_DEF,
   parameter int unsigned TIME_BITS  = dltm_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dltm_pkg::KIND_W-1:0]   req_kind,
   input  logic [dltm_pkg::DUR_W-1:0]    req_duration_ms,
   input  logic [dltm_pkg::ID_W-1:0]     req_timer_id,
   output logic                          rsp_valid,
   output logic [dltm_pkg::RKIND_W-1:0]  rsp_result_kind,
   output logic [dltm_pkg::ID_W-1:0]     rsp_result_id,
   output logic                          rsp_running,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dltm_pkg::TICK_W-1:0]   csr_tick_ms
);
   import dltm_pkg::*;

   localparam int unsigned MT = MAX_TIMERS;
   localparam int unsigned IW = $clog2(MT);
   localparam int unsigned CW = $clog2(MT + 1);
   localparam int unsigned DW = TIME_BITS + 1;
   // ALU is one bit wider than either operand so the top bit is the borrow
   localparam int unsigned AW = ((DW > TICK_W) ? DW : TICK_W) + 1;

   // control state
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [MT-1:0]     running_ff, running_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request and walk registers
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [DW-1:0]     rel_ff, rel_in;
   logic [ID_W-1:0]   tid_ff, tid_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     new_id_ff, new_id_in;
   logic [DW-1:0]     rm_delta_ff, rm_delta_in;
   logic [MT-1:0]     fire_ff, fire_in;

   // delta list; only entries below count_ff are meaningful
   logic [DW-1:0]     delta_ff   [MT];
   logic [DW-1:0]     delta_in   [MT];
   logic [MT-1:0]     members_ff [MT];
   logic [MT-1:0]     members_in [MT];

   // result registers
   logic [RKIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic               rsp_run_ff, rsp_run_in;
   logic               rsp_last_ff, rsp_last_in;

   // helpers
   logic                      accept;
   logic                      free_found;
   logic [IW-1:0]             free_id;
   logic [IW-1:0]             fire_id;
   logic [MT-1:0]             fire_bit, fire_rest;
   logic [MT-1:0]             new_bit;
   logic [DW-1:0]             cur_delta;
   logic [MT-1:0]             cur_members, stop_members;
   logic                      stop_hit;
   logic [31:0]               tid_wide, new_id_wide, fire_id_wide;
   logic                      tid_ok, tid_run;
   logic [IW-1:0]             tid_idx;
   logic [MT-1:0]             tid_bit;
   logic                      at_end;
   logic [DUR_W+TIME_BITS-1:0] dur_ext;
   logic [AW-1:0]             alu_a, alu_b, alu_res;
   logic                      alu_sub, alu_borrow, alu_zero;

   assign accept    = start & ~busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // lowest free id and lowest pending fire id
   always_comb begin
      free_found = 1'b0;
      free_id    = '0;
      fire_id    = '0;
      for (int i = MT - 1; i >= 0; i--) begin
         if (!running_ff[i]) begin
            free_found = 1'b1;
            free_id    = IW'(i);
         end
         if (fire_ff[i]) begin
            fire_id = IW'(i);
         end
      end
   end

   assign fire_bit     = MT'(1) << fire_id;
   assign fire_rest    = fire_ff & ~fire_bit;
   assign new_bit      = MT'(1) << new_id_ff;
   assign cur_delta    = delta_ff[idx_ff];
   assign cur_members  = members_ff[idx_ff];
   assign tid_wide     = 32'(tid_ff);
   assign tid_ok       = (tid_wide < MT);
   assign tid_idx      = tid_wide[IW-1:0];
   assign tid_bit      = MT'(1) << tid_idx;
   assign tid_run      = tid_ok && running_ff[tid_idx];
   assign stop_hit     = |(cur_members & tid_bit);
   assign stop_members = cur_members & ~tid_bit;
   assign at_end       = (CW'(idx_ff) == count_ff);
   assign new_id_wide  = 32'(new_id_ff);
   assign fire_id_wide = 32'(fire_id);
   assign dur_ext      = (DUR_W + TIME_BITS)'(req_duration_ms);

   // shared add/sub unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      unique case (state_ff)
         ST_WALK: begin
            alu_a = AW'(rel_ff);
            alu_b = AW'(cur_delta);
         end
         ST_INSERT: begin
            alu_a = AW'(cur_delta);
            alu_b = AW'(rel_ff);
         end
         ST_FOLD: begin
            alu_a   = AW'(cur_delta);
            alu_b   = AW'(rm_delta_ff);
            alu_sub = 1'b0;
         end
         ST_TICK: begin
            alu_a = AW'(delta_ff[0]);
            alu_b = AW'(tick_ff);
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_res    = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_borrow = alu_res[AW-1];
   assign alu_zero   = (alu_res == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (kind_ff)
               OP_START: state_in = free_found ? ST_WALK : ST_IDLE;
               OP_STOP:  state_in = tid_run ? ST_STOP_WALK : ST_IDLE;
               OP_QUERY: state_in = ST_IDLE;
               OP_TICK:  state_in = (count_ff == '0) ? ST_IDLE : ST_TICK;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_WALK: begin
            priority if (at_end || alu_zero) state_in = ST_IDLE;
            else if (alu_borrow)             state_in = ST_INSERT;
            else                             state_in = ST_WALK;
         end
         ST_INSERT: state_in = ST_IDLE;
         ST_STOP_WALK: begin
            priority if (at_end)                  state_in = ST_IDLE;
            else if (stop_hit && stop_members == '0) state_in = ST_FOLD;
            else if (stop_hit)                    state_in = ST_IDLE;
            else                                  state_in = ST_STOP_WALK;
         end
         ST_FOLD: state_in = ST_IDLE;
         ST_TICK: state_in = (!alu_borrow && !alu_zero) ? ST_IDLE : ST_FIRE;
         ST_FIRE: state_in = (fire_rest == '0) ? ST_IDLE : ST_FIRE;
         default: state_in = ST_IDLE;
      endcase
   end

   // result outputs
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_kind_in  = RES_STARTED;
      rsp_id_in    = '0;
      rsp_run_in   = 1'b0;
      rsp_last_in  = 1'b1;
      unique case (state_ff)
         ST_DISPATCH: begin
            unique case (kind_ff)
               OP_START: begin
                  if (!free_found) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RES_FULL;
                  end
               end
               OP_STOP: begin
                  if (!tid_run) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = RES_STOP_ACK;
                     rsp_id_in    = tid_ff;
                  end
               end
               OP_QUERY: begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = RES_QUERY;
                  rsp_id_in    = tid_ff;
                  rsp_run_in   = tid_run;
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
         end
         ST_WALK: begin
            if (at_end || alu_zero) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = new_id_wide[ID_W-1:0];
            end
         end
         ST_INSERT: begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = new_id_wide[ID_W-1:0];
         end
         ST_STOP_WALK: begin
            if (at_end || (stop_hit && stop_members != '0)) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = RES_STOP_ACK;
               rsp_id_in    = tid_ff;
            end
         end
         ST_FOLD: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = RES_STOP_ACK;
            rsp_id_in    = tid_ff;
         end
         ST_FIRE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = RES_FIRED;
            rsp_id_in    = fire_id_wide[ID_W-1:0];
            rsp_last_in  = (fire_rest == '0);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // datapath: list edits, walk registers
   always_comb begin
      kind_in     = kind_ff;
      rel_in      = rel_ff;
      tid_in      = tid_ff;
      idx_in      = idx_ff;
      new_id_in   = new_id_ff;
      rm_delta_in = rm_delta_ff;
      fire_in     = fire_ff;
      count_in    = count_ff;
      running_in  = running_ff;
      tick_in     = (csr_valid && csr_ready) ? csr_tick_ms : tick_ff;
      for (int j = 0; j < MT; j++) begin
         delta_in[j]   = delta_ff[j];
         members_in[j] = members_ff[j];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               rel_in  = DW'(dur_ext[TIME_BITS-1:0]);
               tid_in  = req_timer_id;
            end
         end
         ST_DISPATCH: begin
            idx_in    = '0;
            new_id_in = free_id;
         end
         ST_WALK: begin
            priority if (at_end) begin
               // append a new tail group
               delta_in[idx_ff]   = rel_ff;
               members_in[idx_ff] = new_bit;
               count_in           = count_ff + CW'(1);
               running_in         = running_ff | new_bit;
            end else if (alu_zero) begin
               members_in[idx_ff] = cur_members | new_bit;
               running_in         = running_ff | new_bit;
            end else if (!alu_borrow) begin
               rel_in = alu_res[DW-1:0];
               idx_in = idx_ff + IW'(1);
            end
         end
         ST_INSERT: begin
            // open a slot at idx, successor keeps the remainder
            for (int j = 1; j < MT; j++) begin
               if (j > int'(idx_ff) + 1) begin
                  delta_in[j]   = delta_ff[j-1];
                  members_in[j] = members_ff[j-1];
               end else if (j == int'(idx_ff) + 1) begin
                  delta_in[j]   = alu_res[DW-1:0];
                  members_in[j] = cur_members;
               end
            end
            delta_in[idx_ff]   = rel_ff;
            members_in[idx_ff] = new_bit;
            count_in           = count_ff + CW'(1);
            running_in         = running_ff | new_bit;
         end
         ST_STOP_WALK: begin
            if (!at_end) begin
               if (stop_hit) begin
                  running_in = running_ff & ~tid_bit;
                  if (stop_members == '0) begin
                     // drop the group; its delta is folded in next cycle
                     for (int j = 0; j < MT - 1; j++) begin
                        if (j >= int'(idx_ff)) begin
                           delta_in[j]   = delta_ff[j+1];
                           members_in[j] = members_ff[j+1];
                        end
                     end
                     rm_delta_in = cur_delta;
                     count_in    = count_ff - CW'(1);
                  end else begin
                     members_in[idx_ff] = stop_members;
                  end
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         ST_FOLD: begin
            if (CW'(idx_ff) < count_ff) begin
               delta_in[idx_ff] = alu_res[DW-1:0];
            end
         end
         ST_TICK: begin
            if (!alu_borrow && !alu_zero) begin
               delta_in[0] = alu_res[DW-1:0];
            end else begin
               // head expires: pop it and queue its members for firing
               fire_in    = members_ff[0];
               running_in = running_ff & ~members_ff[0];
               count_in   = count_ff - CW'(1);
               for (int j = 0; j < MT - 1; j++) begin
                  delta_in[j]   = delta_ff[j+1];
                  members_in[j] = members_ff[j+1];
               end
            end
         end
         ST_FIRE: begin
            fire_in = fire_rest;
         end
         default: begin
            fire_in = fire_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         running_ff   <= '0;
         tick_ff      <= TICK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rel_ff      <= rel_in;
      tid_ff      <= tid_in;
      idx_ff      <= idx_in;
      new_id_ff   <= new_id_in;
      rm_delta_ff <= rm_delta_in;
      fire_ff     <= fire_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_last_ff <= rsp_last_in;
      for (int j = 0; j < MT; j++) begin
         delta_ff[j]   <= delta_in[j];
         members_ff[j] <= members_in[j];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_running     = rsp_run_ff;
   assign rsp_last        = rsp_last_ff;

   // no more groups than running timers, as every group holds at least one
   `DLTM_ASSERT_IMP(a_groups_le_running, clock, reset, 1'b1, $countones(running_ff) >= count_ff)
   // a burst of fire results is never broken
   `DLTM_ASSERT_NXT(a_fire_burst, clock, reset, rsp_valid_ff && !rsp_last_ff, rsp_valid_ff)
   // an accepted request raises busy
   `DLTM_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   // firing always has a pending id
   `DLTM_ASSERT_IMP(a_fire_pending, clock, reset, state_ff == ST_FIRE, fire_ff != '0)

endmodule
